// ===== src/mvne_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the mesh vertex normal engine.
package mvne_pkg;

    localparam int SUM_W     = 62;
    localparam int FIT_W     = 24;
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int SQ_W      = 48;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int FRAC_W    = 14;
    localparam int NUM_W     = FIT_W + FRAC_W;
    localparam int NORM_W    = 16;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 24;
    localparam int Q14_ONE   = 16384;
    localparam int FACE_MULS = 6;
    localparam int AXES      = 3;

    typedef enum logic [1:0] {
        OP_VERTEX = 2'd0,
        OP_FACE   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_RDB,
        ST_F_DIFF,
        ST_F_MUL,
        ST_F_RD,
        ST_F_WR,
        ST_Q_CHK,
        ST_Q_FIT,
        ST_Q_SQ,
        ST_Q_SQRT,
        ST_Q_DIV,
        ST_Q_DONE
    } t_state;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [IDX_W-1:0]         vert;
        logic                     nn;
    } t_result;

endpackage

// ===== src/mvne_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command and normal transactions.
interface mvne_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [mvne_pkg::POS_W-1:0]   pos_x;
    logic signed [mvne_pkg::POS_W-1:0]   pos_y;
    logic signed [mvne_pkg::POS_W-1:0]   pos_z;
    logic [mvne_pkg::IDX_W-1:0]          corner_a;
    logic [mvne_pkg::IDX_W-1:0]          corner_b;
    logic [mvne_pkg::IDX_W-1:0]          corner_c;
    logic [mvne_pkg::IDX_W-1:0]          vertex_sel;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, corner_a, corner_b,
                    corner_c, vertex_sel, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, corner_a, corner_b,
                    corner_c, vertex_sel, output ready);
endinterface

interface mvne_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mvne_pkg::NORM_W-1:0]  normal_x;
    logic signed [mvne_pkg::NORM_W-1:0]  normal_y;
    logic signed [mvne_pkg::NORM_W-1:0]  normal_z;
    logic [mvne_pkg::IDX_W-1:0]          queried_vertex;
    logic                                no_normal;

    modport source (output valid, normal_x, normal_y, normal_z, queried_vertex,
                    no_normal, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, queried_vertex,
                    no_normal, output ready);
endinterface

// ===== src/mesh_vertex_normal_engine_top.sv =====
`timescale 1ns / 1ps
// Top level of the mesh vertex normal engine: stores, sequencer and result register.
//
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid/ready        | opcode, pos_x/y/z, corner_a/b/c, vertex_sel
//  o_out    | out | valid/ready        | normal_x/y/z, queried_vertex, no_normal
//
// Load vertex keeps the engine idle. Load face uses the bit-serial multiplier, which forms
// six partial products in turn. Query uses the shift-to-fit loop, the serial square root
// and the serial divider.
// Reset and clear object run a clearing pass over all MAX_VERTS sum entries with i_in.ready low.
// A finished normal waits in the output register while the next transaction is taken.
module mesh_vertex_normal_engine_top #(
    parameter int MAX_VERTS  = 1024,
    parameter int MAX_FACES  = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvne_in_if.sink     i_in,
    mvne_out_if.source  o_out
);
    localparam int AW  = $clog2(MAX_VERTS);
    localparam int CW  = $clog2(MAX_VERTS + 1);
    localparam int SCW = $clog2(MAX_FACES + 1);
    localparam int CB  = COORD_BITS;
    localparam int MW  = mvne_pkg::MUL_W;
    localparam int SW  = mvne_pkg::SUM_W;
    localparam int FW  = mvne_pkg::FIT_W;
    localparam int NMW = mvne_pkg::NORM_W;

    mvne_pkg::t_state  r_state, n_state;
    mvne_pkg::t_opcode in_op;
    mvne_pkg::t_result r_res, r_opay;

    logic [CW-1:0]  r_vcount, n_vcount;
    logic [AW-1:0]  r_clr, n_clr;
    logic [2:0]     r_step, n_step;
    logic [1:0]     r_idx, n_idx;
    logic           r_go, n_go;
    logic           r_ovalid, n_ovalid;
    logic           in_acc, face_ok, pos_we, sum_we, push;
    logic           mul_start, sqrt_start, div_start;
    logic           mul_done, sqrt_done, div_done;

    logic signed [CB-1:0] r_px [MAX_VERTS];
    logic signed [CB-1:0] r_py [MAX_VERTS];
    logic signed [CB-1:0] r_pz [MAX_VERTS];
    logic signed [CB-1:0] r_p0x, r_p0y, r_p0z, r_p1x, r_p1y, r_p1z;
    logic [AW-1:0]        rd0, rd1, r_ca, r_cb, r_cc, corner_sel, sum_ra, sum_wa;

    logic [SW-1:0]  r_msx [MAX_VERTS];
    logic [SW-1:0]  r_msy [MAX_VERTS];
    logic [SW-1:0]  r_msz [MAX_VERTS];
    logic [SCW-1:0] r_mcnt [MAX_VERTS];
    logic [SW-1:0]  r_rdx, r_rdy, r_rdz, wx, wy, wz;
    logic [SCW-1:0] r_rdc, wc;

    logic signed [MW-1:0] r_ux, r_uy, r_uz, r_wx, r_wy, r_wz;
    logic signed [MW-1:0] r_vx, r_vy, r_vz, mul_a, mul_b, div_c;
    logic signed [mvne_pkg::PROD_W-1:0]  r_ptmp, mul_prod;
    logic signed [mvne_pkg::CROSS_W-1:0] r_cx, r_cy, r_cz;
    logic signed [SW-1:0]                r_sx, r_sy, r_sz;
    logic [mvne_pkg::SQ_W-1:0]   r_nsq;
    logic [mvne_pkg::ROOT_W-1:0] r_m, sqrt_root;
    logic [mvne_pkg::NUM_W-1:0]  div_num, div_q;
    logic [MW-1:0]               div_mag;
    logic [NMW-1:0]              q_clamp;
    logic signed [NMW-1:0]       comp;
    logic [mvne_pkg::IDX_W-1:0]  r_qsel;
    logic fit_x, fit_y, fit_z, no_sum;

    assign in_op   = mvne_pkg::t_opcode'(i_in.opcode);
    assign in_acc  = i_in.valid && i_in.ready;
    assign face_ok = (32'(i_in.corner_a) < 32'(r_vcount))
                  && (32'(i_in.corner_b) < 32'(r_vcount))
                  && (32'(i_in.corner_c) < 32'(r_vcount));
    assign pos_we  = in_acc && (in_op == mvne_pkg::OP_VERTEX)
                  && (32'(r_vcount) < MAX_VERTS);
    assign i_in.ready = (r_state == mvne_pkg::ST_IDLE);

    // position store
    assign rd0 = (r_state == mvne_pkg::ST_IDLE) ? AW'(i_in.corner_a) : r_cb;
    assign rd1 = (r_state == mvne_pkg::ST_IDLE) ? AW'(i_in.corner_c) : r_cc;

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_px[r_vcount[AW-1:0]] <= i_in.pos_x[CB-1:0];
            r_py[r_vcount[AW-1:0]] <= i_in.pos_y[CB-1:0];
            r_pz[r_vcount[AW-1:0]] <= i_in.pos_z[CB-1:0];
        end
        r_p0x <= r_px[rd0];
        r_p0y <= r_py[rd0];
        r_p0z <= r_pz[rd0];
        r_p1x <= r_px[rd1];
        r_p1y <= r_py[rd1];
        r_p1z <= r_pz[rd1];
    end

    // sum store
    always_comb begin
        case (r_idx)
            2'd0:    corner_sel = r_ca;
            2'd1:    corner_sel = r_cb;
            default: corner_sel = r_cc;
        endcase
    end

    assign sum_ra = (r_state == mvne_pkg::ST_IDLE) ? AW'(i_in.vertex_sel) : corner_sel;
    assign sum_wa = (r_state == mvne_pkg::ST_CLEAR) ? r_clr : corner_sel;
    assign wx = (r_state == mvne_pkg::ST_CLEAR) ? '0 : r_rdx + SW'(r_cx);
    assign wy = (r_state == mvne_pkg::ST_CLEAR) ? '0 : r_rdy + SW'(r_cy);
    assign wz = (r_state == mvne_pkg::ST_CLEAR) ? '0 : r_rdz + SW'(r_cz);
    assign wc = (r_state == mvne_pkg::ST_CLEAR) ? '0 :
                (32'(r_rdc) < MAX_FACES) ? r_rdc + SCW'(1) : r_rdc;

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_msx[sum_wa]  <= wx;
            r_msy[sum_wa]  <= wy;
            r_msz[sum_wa]  <= wz;
            r_mcnt[sum_wa] <= wc;
        end
        r_rdx <= r_msx[sum_ra];
        r_rdy <= r_msy[sum_ra];
        r_rdz <= r_msz[sum_ra];
        r_rdc <= r_mcnt[sum_ra];
    end

    // arithmetic units
    always_comb begin
        mul_a = r_vx;
        mul_b = r_vx;
        if (r_state == mvne_pkg::ST_Q_SQ) begin
            case (r_step)
                3'd0:    begin mul_a = r_vx; mul_b = r_vx; end
                3'd1:    begin mul_a = r_vy; mul_b = r_vy; end
                default: begin mul_a = r_vz; mul_b = r_vz; end
            endcase
        end else begin
            case (r_step)
                3'd0:    begin mul_a = r_uy; mul_b = r_wz; end
                3'd1:    begin mul_a = r_uz; mul_b = r_wy; end
                3'd2:    begin mul_a = r_uz; mul_b = r_wx; end
                3'd3:    begin mul_a = r_ux; mul_b = r_wz; end
                3'd4:    begin mul_a = r_ux; mul_b = r_wy; end
                default: begin mul_a = r_uy; mul_b = r_wx; end
            endcase
        end
    end

    always_comb begin
        case (r_step)
            3'd0:    div_c = r_vx;
            3'd1:    div_c = r_vy;
            default: div_c = r_vz;
        endcase
    end

    assign div_mag = div_c[MW-1] ? -div_c : div_c;
    assign div_num = mvne_pkg::NUM_W'({div_mag[FW-1:0], mvne_pkg::FRAC_W'(0)})
                   + mvne_pkg::NUM_W'(r_m >> 1);
    assign q_clamp = (div_q > mvne_pkg::NUM_W'(mvne_pkg::Q14_ONE))
                   ? NMW'(mvne_pkg::Q14_ONE) : div_q[NMW-1:0];
    assign comp    = div_c[MW-1] ? -$signed(q_clamp) : $signed(q_clamp);

    mvne_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mvne_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (r_nsq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    mvne_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_m),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign fit_x  = (&r_sx[SW-1:FW-1]) || !(|r_sx[SW-1:FW-1]);
    assign fit_y  = (&r_sy[SW-1:FW-1]) || !(|r_sy[SW-1:FW-1]);
    assign fit_z  = (&r_sz[SW-1:FW-1]) || !(|r_sz[SW-1:FW-1]);
    assign no_sum = (32'(r_qsel) >= MAX_VERTS) || (r_rdc == '0)
                 || ((r_rdx == '0) && (r_rdy == '0) && (r_rdz == '0));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mvne_pkg::ST_CLEAR;
            r_vcount <= '0;
            r_clr    <= '0;
            r_step   <= '0;
            r_idx    <= '0;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vcount <= n_vcount;
            r_clr    <= n_clr;
            r_step   <= n_step;
            r_idx    <= n_idx;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_vcount   = r_vcount;
        n_clr      = r_clr;
        n_step     = r_step;
        n_idx      = r_idx;
        n_go       = r_go;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        sum_we     = 1'b0;
        push       = 1'b0;
        case (r_state)
            mvne_pkg::ST_CLEAR: begin
                sum_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(MAX_VERTS - 1)) begin
                    n_state = mvne_pkg::ST_IDLE;
                end
            end
            mvne_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        mvne_pkg::OP_VERTEX: begin
                            if (pos_we) begin
                                n_vcount = r_vcount + CW'(1);
                            end
                        end
                        mvne_pkg::OP_FACE: begin
                            if (face_ok) begin
                                n_state = mvne_pkg::ST_F_RDB;
                            end
                        end
                        mvne_pkg::OP_QUERY: begin
                            n_state = mvne_pkg::ST_Q_CHK;
                        end
                        mvne_pkg::OP_CLEAR: begin
                            n_vcount = '0;
                            n_clr    = '0;
                            n_state  = mvne_pkg::ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            mvne_pkg::ST_F_RDB: begin
                n_state = mvne_pkg::ST_F_DIFF;
            end
            mvne_pkg::ST_F_DIFF: begin
                n_step  = '0;
                n_go    = 1'b0;
                n_state = mvne_pkg::ST_F_MUL;
            end
            mvne_pkg::ST_F_MUL: begin
                mul_start = !r_go;
                n_go      = 1'b1;
                if (mul_done) begin
                    n_go   = 1'b0;
                    n_step = r_step + 3'd1;
                    if (r_step == 3'(mvne_pkg::FACE_MULS - 1)) begin
                        n_idx   = '0;
                        n_state = mvne_pkg::ST_F_RD;
                    end
                end
            end
            mvne_pkg::ST_F_RD: begin
                n_state = mvne_pkg::ST_F_WR;
            end
            mvne_pkg::ST_F_WR: begin
                sum_we = 1'b1;
                n_idx  = r_idx + 2'd1;
                if (r_idx == 2'(mvne_pkg::AXES - 1)) begin
                    n_state = mvne_pkg::ST_IDLE;
                end else begin
                    n_state = mvne_pkg::ST_F_RD;
                end
            end
            mvne_pkg::ST_Q_CHK: begin
                n_state = no_sum ? mvne_pkg::ST_Q_DONE : mvne_pkg::ST_Q_FIT;
            end
            mvne_pkg::ST_Q_FIT: begin
                if (fit_x && fit_y && fit_z) begin
                    n_step  = '0;
                    n_go    = 1'b0;
                    n_state = mvne_pkg::ST_Q_SQ;
                end
            end
            mvne_pkg::ST_Q_SQ: begin
                mul_start = !r_go;
                n_go      = 1'b1;
                if (mul_done) begin
                    n_go   = 1'b0;
                    n_step = r_step + 3'd1;
                    if (r_step == 3'(mvne_pkg::AXES - 1)) begin
                        n_state = mvne_pkg::ST_Q_SQRT;
                    end
                end
            end
            mvne_pkg::ST_Q_SQRT: begin
                sqrt_start = !r_go;
                n_go       = 1'b1;
                if (sqrt_done) begin
                    n_go    = 1'b0;
                    n_step  = '0;
                    n_state = (sqrt_root == '0) ? mvne_pkg::ST_Q_DONE : mvne_pkg::ST_Q_DIV;
                end
            end
            mvne_pkg::ST_Q_DIV: begin
                div_start = !r_go;
                n_go      = 1'b1;
                if (div_done) begin
                    n_go   = 1'b0;
                    n_step = r_step + 3'd1;
                    if (r_step == 3'(mvne_pkg::AXES - 1)) begin
                        n_state = mvne_pkg::ST_Q_DONE;
                    end
                end
            end
            mvne_pkg::ST_Q_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    push    = 1'b1;
                    n_state = mvne_pkg::ST_IDLE;
                end
            end
            default: n_state = mvne_pkg::ST_CLEAR;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mvne_pkg::ST_IDLE: begin
                r_ca   <= AW'(i_in.corner_a);
                r_cb   <= AW'(i_in.corner_b);
                r_cc   <= AW'(i_in.corner_c);
                r_qsel <= i_in.vertex_sel;
            end
            mvne_pkg::ST_F_RDB: begin
                r_ux <= MW'(r_p0x) - MW'(r_p1x);
                r_uy <= MW'(r_p0y) - MW'(r_p1y);
                r_uz <= MW'(r_p0z) - MW'(r_p1z);
            end
            mvne_pkg::ST_F_DIFF: begin
                r_wx <= MW'(r_p1x) - MW'(r_p0x);
                r_wy <= MW'(r_p1y) - MW'(r_p0y);
                r_wz <= MW'(r_p1z) - MW'(r_p0z);
            end
            mvne_pkg::ST_F_MUL: begin
                if (mul_done) begin
                    if (!r_step[0]) begin
                        r_ptmp <= mul_prod;
                    end else begin
                        case (r_step[2:1])
                            2'd0:    r_cx <= mvne_pkg::CROSS_W'(r_ptmp)
                                           - mvne_pkg::CROSS_W'(mul_prod);
                            2'd1:    r_cy <= mvne_pkg::CROSS_W'(r_ptmp)
                                           - mvne_pkg::CROSS_W'(mul_prod);
                            default: r_cz <= mvne_pkg::CROSS_W'(r_ptmp)
                                           - mvne_pkg::CROSS_W'(mul_prod);
                        endcase
                    end
                end
            end
            mvne_pkg::ST_Q_CHK: begin
                r_sx      <= r_rdx;
                r_sy      <= r_rdy;
                r_sz      <= r_rdz;
                r_res.nx  <= '0;
                r_res.ny  <= '0;
                r_res.nz  <= '0;
                r_res.vert <= r_qsel;
                r_res.nn  <= 1'b1;
            end
            mvne_pkg::ST_Q_FIT: begin
                if (fit_x && fit_y && fit_z) begin
                    r_vx  <= -MW'($signed(r_sx[FW-1:0]));
                    r_vy  <= -MW'($signed(r_sy[FW-1:0]));
                    r_vz  <= -MW'($signed(r_sz[FW-1:0]));
                    r_nsq <= '0;
                end else begin
                    r_sx <= r_sx >>> 1;
                    r_sy <= r_sy >>> 1;
                    r_sz <= r_sz >>> 1;
                end
            end
            mvne_pkg::ST_Q_SQ: begin
                if (mul_done) begin
                    r_nsq <= r_nsq + mul_prod[mvne_pkg::SQ_W-1:0];
                end
            end
            mvne_pkg::ST_Q_SQRT: begin
                if (sqrt_done) begin
                    r_m <= sqrt_root;
                end
            end
            mvne_pkg::ST_Q_DIV: begin
                if (div_done) begin
                    case (r_step)
                        3'd0:    r_res.nx <= comp;
                        3'd1:    r_res.ny <= comp;
                        default: begin
                            r_res.nz <= comp;
                            r_res.nn <= 1'b0;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid;
        if (push) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_opay <= r_res;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.normal_x       = r_opay.nx;
    assign o_out.normal_y       = r_opay.ny;
    assign o_out.normal_z       = r_opay.nz;
    assign o_out.queried_vertex = r_opay.vert;
    assign o_out.no_normal      = r_opay.nn;
endmodule

// ===== src/mvne_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial signed multiplier, one multiplier bit per cycle.
module mvne_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mvne_pkg::MUL_W-1:0]   i_a,
    input  logic signed [mvne_pkg::MUL_W-1:0]   i_b,
    output logic                                o_done,
    output logic signed [mvne_pkg::PROD_W-1:0]  o_prod
);
    localparam int MW    = mvne_pkg::MUL_W;
    localparam int CNT_W = $clog2(MW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MW-1:0]    r_a;
    logic [MW:0]      r_hi;
    logic [MW-1:0]    r_lo;
    logic             r_neg;
    logic [MW:0]      sum;
    logic [mvne_pkg::PROD_W-1:0] mag;

    assign sum    = r_hi + (r_lo[0] ? {1'b0, r_a} : '0);
    assign mag    = {r_hi[MW-1:0], r_lo};
    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(mag) : $signed(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a[MW-1] ? -i_a : i_a;
            r_lo  <= i_b[MW-1] ? -i_b : i_b;
            r_hi  <= '0;
            r_neg <= i_a[MW-1] ^ i_b[MW-1];
        end else if (r_busy) begin
            r_hi <= {1'b0, sum[MW:1]};
            r_lo <= {sum[0], r_lo[MW-1:1]};
        end
    end
endmodule

// ===== src/mvne_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-serial integer square root, one root bit per cycle.
module mvne_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mvne_pkg::SQ_W-1:0]          i_n,
    output logic                               o_done,
    output logic [mvne_pkg::ROOT_W-1:0]        o_root
);
    localparam int NW    = mvne_pkg::SQ_W;
    localparam int RW    = mvne_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_n;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [RW+3:0]    wide;
    logic [RW+3:0]    trial;
    logic             take;

    assign wide   = {r_rem, r_n[NW-1:NW-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = wide >= trial;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[NW-3:0], 2'b00};
            r_rem  <= take ? (RW+2)'(wide - trial) : wide[RW+1:0];
            r_root <= {r_root[RW-2:0], take};
        end
    end
endmodule

// ===== src/mvne_div.sv =====
`timescale 1ns / 1ps
// Restoring bit-serial divider, one quotient bit per cycle.
module mvne_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [mvne_pkg::NUM_W-1:0]         i_num,
    input  logic [mvne_pkg::ROOT_W-1:0]        i_den,
    output logic                               o_done,
    output logic [mvne_pkg::NUM_W-1:0]         o_quot
);
    localparam int NW    = mvne_pkg::NUM_W;
    localparam int DW    = mvne_pkg::ROOT_W;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;
    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [DW:0]      wide;
    logic             take;

    assign wide   = {r_rem, r_num[NW-1]};
    assign take   = wide >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= take ? DW'(wide - {1'b0, r_den}) : wide[DW-1:0];
            r_q   <= {r_q[NW-2:0], take};
        end
    end
endmodule

// ===== src/mvne_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker of the mesh vertex normal engine and its bind.
module mvne_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [mvne_pkg::NORM_W-1:0] i_nx,
    input logic signed [mvne_pkg::NORM_W-1:0] i_ny,
    input logic signed [mvne_pkg::NORM_W-1:0] i_nz,
    input logic [mvne_pkg::IDX_W-1:0]         i_vert,
    input logic                               i_nn
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_nx) && $stable(i_ny)
            && $stable(i_nz) && $stable(i_vert) && $stable(i_nn))
        else $error("result payload changed while stalled");

    a_nn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_nn |-> i_nx == 0 && i_ny == 0 && i_nz == 0)
        else $error("flagged result carries a nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_nx <= 16384 && i_nx >= -16384 && i_ny <= 16384
            && i_ny >= -16384 && i_nz <= 16384 && i_nz >= -16384)
        else $error("normal component outside unit range");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input taken during clearing pass after reset");
endmodule

bind mesh_vertex_normal_engine_top mvne_chk u_mvne_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_nx        (o_out.normal_x),
    .i_ny        (o_out.normal_y),
    .i_nz        (o_out.normal_z),
    .i_vert      (o_out.queried_vertex),
    .i_nn        (o_out.no_normal)
);

// ===== sim/mvne_checker.sv =====
`timescale 1ns / 1ps
// Normal checker: watches both channels, predicts vertex normals and compares results.
module mvne_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvne_in_if          i_in,
    mvne_out_if         o_out,
    output int          o_errors,
    output int          o_pending
);
    localparam int NVERT = 1024;
    localparam int NFACE = 1024;

    logic signed [23:0] pos_x [NVERT];
    logic signed [23:0] pos_y [NVERT];
    logic signed [23:0] pos_z [NVERT];
    logic signed [61:0] acc_x [NVERT];
    logic signed [61:0] acc_y [NVERT];
    logic signed [61:0] acc_z [NVERT];
    int unsigned        shares [NVERT];
    int unsigned        loaded;
    mvne_pkg::t_result  normals_due [$];

    function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int k);
        return v >>> k;
    endfunction

    function automatic logic fits(logic signed [63:0] v);
        return v >= -64'sd8388608 && v <= 64'sd8388607;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [15:0] unit_comp(logic signed [63:0] c, logic [63:0] m);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c < 0 ? -c : c;
        q = (mag * mvne_pkg::Q14_ONE + m / 2) / m;
        if (q > mvne_pkg::Q14_ONE) q = mvne_pkg::Q14_ONE;
        return c < 0 ? -q[15:0] : q[15:0];
    endfunction

    function automatic mvne_pkg::t_result vertex_normal(int unsigned v);
        mvne_pkg::t_result r;
        logic signed [63:0] sx, sy, sz, x, y, z;
        logic [63:0] m;
        int k;
        r = '0;
        r.vert = v[9:0];
        r.nn = 1'b1;
        if (shares[v] == 0) return r;
        sx = acc_x[v];
        sy = acc_y[v];
        sz = acc_z[v];
        if (sx == 0 && sy == 0 && sz == 0) return r;
        k = 0;
        while (k < 62 && !(fits(floor_shr(sx, k)) && fits(floor_shr(sy, k))
                           && fits(floor_shr(sz, k))))
            k++;
        x = -floor_shr(sx, k);
        y = -floor_shr(sy, k);
        z = -floor_shr(sz, k);
        m = int_sqrt(x * x + y * y + z * z);
        if (m == 0) return r;
        r.nx = unit_comp(x, m);
        r.ny = unit_comp(y, m);
        r.nz = unit_comp(z, m);
        r.nn = 1'b0;
        return r;
    endfunction

    task automatic add_corner(int unsigned v, logic signed [63:0] cx,
                              logic signed [63:0] cy, logic signed [63:0] cz);
        acc_x[v] = acc_x[v] + cx[61:0];
        acc_y[v] = acc_y[v] + cy[61:0];
        acc_z[v] = acc_z[v] + cz[61:0];
        if (shares[v] < NFACE) shares[v]++;
    endtask

    task automatic apply_face(int unsigned a, int unsigned b, int unsigned c);
        logic signed [63:0] ux, uy, uz, wx, wy, wz;
        if (a >= loaded || b >= loaded || c >= loaded) return;
        ux = 64'(pos_x[a]) - 64'(pos_x[c]);
        uy = 64'(pos_y[a]) - 64'(pos_y[c]);
        uz = 64'(pos_z[a]) - 64'(pos_z[c]);
        wx = 64'(pos_x[c]) - 64'(pos_x[b]);
        wy = 64'(pos_y[c]) - 64'(pos_y[b]);
        wz = 64'(pos_z[c]) - 64'(pos_z[b]);
        add_corner(a, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
        add_corner(b, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
        add_corner(c, uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
    endtask

    task automatic clear_object();
        for (int i = 0; i < NVERT; i++) begin
            acc_x[i] = '0;
            acc_y[i] = '0;
            acc_z[i] = '0;
            shares[i] = 0;
        end
        loaded = 0;
    endtask

    assign o_pending = normals_due.size();

    initial begin
        o_errors = 0;
        clear_object();
    end

    always @(posedge i_clk) begin
        mvne_pkg::t_result got;
        mvne_pkg::t_result want;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            case (mvne_pkg::t_opcode'(i_in.opcode))
                mvne_pkg::OP_VERTEX: begin
                    if (loaded < NVERT) begin
                        pos_x[loaded] = i_in.pos_x;
                        pos_y[loaded] = i_in.pos_y;
                        pos_z[loaded] = i_in.pos_z;
                        loaded++;
                    end
                end
                mvne_pkg::OP_FACE:  apply_face(i_in.corner_a, i_in.corner_b, i_in.corner_c);
                mvne_pkg::OP_QUERY: normals_due = {normals_due,
                                                   vertex_normal(i_in.vertex_sel)};
                mvne_pkg::OP_CLEAR: clear_object();
                default: ;
            endcase
        end
        if (i_rst_n && o_out.valid && o_out.ready) begin
            got = {o_out.normal_x, o_out.normal_y, o_out.normal_z, o_out.queried_vertex,
                   o_out.no_normal};
            if (normals_due.size() == 0) begin
                o_errors++;
                if (o_errors <= 10) $display("unexpected normal transaction %p", got);
            end else begin
                want = normals_due.pop_front();
                if (got != want) begin
                    o_errors++;
                    if (o_errors <= 10) $display("normal mismatch: expected %p actual %p",
                                                 want, got);
                end
            end
        end
    end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives mesh commands with random gaps and gives the verdict.
module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   nverts;

    mvne_in_if  cmd ();
    mvne_out_if nrm ();

    mesh_vertex_normal_engine_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd),
        .o_out   (nrm)
    );

    mvne_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (cmd),
        .o_out     (nrm),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800001;
            2: return 24'h800000;
            3: return 24'($signed($urandom_range(0, 200)) - 100);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send(mvne_pkg::t_opcode op, logic [23:0] x, logic [23:0] y,
                        logic [23:0] z, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                        logic [9:0] s);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap != 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd.valid <= 1'b1;
        cmd.opcode <= op;
        cmd.pos_x <= x;
        cmd.pos_y <= y;
        cmd.pos_z <= z;
        cmd.corner_a <= a;
        cmd.corner_b <= b;
        cmd.corner_c <= c;
        cmd.vertex_sel <= s;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == mvne_pkg::OP_VERTEX && nverts < 1024) nverts++;
        if (op == mvne_pkg::OP_CLEAR) nverts = 0;
    endtask

    task automatic vert(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        send(mvne_pkg::OP_VERTEX, x, y, z, 10'($urandom), 10'($urandom), 10'($urandom),
             10'($urandom));
    endtask

    task automatic face(logic [9:0] a, logic [9:0] b, logic [9:0] c);
        send(mvne_pkg::OP_FACE, 24'($urandom), 24'($urandom), 24'($urandom), a, b, c,
             10'($urandom));
    endtask

    task automatic query(logic [9:0] s);
        send(mvne_pkg::OP_QUERY, 24'($urandom), 24'($urandom), 24'($urandom),
             10'($urandom), 10'($urandom), 10'($urandom), s);
    endtask

    function automatic logic [9:0] pick();
        if (nverts == 0 || $urandom_range(0, 15) == 0) return 10'($urandom);
        return 10'($urandom_range(0, nverts - 1));
    endfunction

    initial begin
        int hold_cycles;
        nrm.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            hold_cycles = $urandom_range(0, 11);
            if (hold_cycles != 0) begin
                nrm.ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
            end
            nrm.ready <= 1'b1;
            @(posedge i_clk);
            while (!(nrm.valid && nrm.ready)) @(posedge i_clk);
        end
    end

    initial begin
        cmd.valid = 1'b0;
        cmd.opcode = mvne_pkg::OP_VERTEX;
        cmd.pos_x = '0;
        cmd.pos_y = '0;
        cmd.pos_z = '0;
        cmd.corner_a = '0;
        cmd.corner_b = '0;
        cmd.corner_c = '0;
        cmd.vertex_sel = '0;
        nverts = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        query(10'd0);
        query(10'd1023);
        vert(24'h7FFFFF, 24'h800001, 24'h000000);
        vert(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
        vert(24'h000000, 24'h000000, 24'h800000);
        vert(24'h000005, 24'h000005, 24'h000005);
        face(10'd0, 10'd1, 10'd2);
        face(10'd0, 10'd1, 10'd9);
        face(10'd3, 10'd3, 10'd3);
        face(10'd1023, 10'd1023, 10'd1023);
        query(10'd0);
        query(10'd1);
        query(10'd2);
        query(10'd3);
        query(10'd9);
        send(mvne_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        query(10'd0);
        vert(24'd0, 24'd0, 24'd0);
        vert(24'd100, 24'd0, 24'd0);
        vert(24'd0, 24'd100, 24'd0);
        face(10'd0, 10'd1, 10'd2);
        face(10'd0, 10'd2, 10'd1);
        query(10'd0);
        query(10'd2);

        for (int i = 0; i < 120; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: vert(rand_coord(), rand_coord(), rand_coord());
                5, 6, 7, 8, 9, 10, 11, 12: face(pick(), pick(), pick());
                19: begin
                    if ($urandom_range(0, 3) == 0)
                        send(mvne_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
                    else query(pick());
                end
                default: query(pick());
            endcase
        end
        for (int i = 0; i < 1030; i++) vert(rand_coord(), rand_coord(), rand_coord());
        for (int i = 0; i < 280; i++) begin
            if ($urandom_range(0, 2) == 0) query(10'($urandom));
            else face(10'($urandom), 10'($urandom), 10'($urandom));
        end
        cmd.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
